// ----- hdl/crat_pkg.sv -----
package crat_pkg;

	// sizes of the block
	localparam int unsigned LEAVES_DEF = 65536;
	localparam int unsigned POS_W      = 17;
	localparam int unsigned VAL_W      = 64;

	localparam logic [POS_W-1:0] SIZE_RESET  = 17'd65536;
	localparam logic [VAL_W-1:0] NEUTRAL_MIN = 64'h7FFF_FFFF_FFFF_FFFF;

	// request word: one range add or range minimum query
	typedef struct packed {
		logic                func;
		logic [POS_W-1:0]    first_position;
		logic [POS_W-1:0]    last_position;
		logic signed [31:0]  amount;
	} req_word_t;

	// response word
	typedef struct packed {
		logic signed [VAL_W-1:0] min_value;
		logic                    was_query;
		logic                    bad_range;
	} rsp_word_t;

	// one tree node: pending add and subtree minimum
	typedef struct packed {
		logic [VAL_W-1:0] ad;
		logic [VAL_W-1:0] mn;
	} node_t;

	typedef enum logic [1:0] {
		ALU_BUMP,
		ALU_MIN,
		ALU_ADDMN
	} alu_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PSEL,
		ST_PCHK,
		ST_PC0,
		ST_PC1,
		ST_PNX,
		ST_CL,
		ST_CR,
		ST_SH,
		ST_VIS,
		ST_RC0,
		ST_RC1,
		ST_RC2,
		ST_RC3,
		ST_RC4,
		ST_DONE
	} eng_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_RUN1,
		T_RUN2,
		T_WAIT
	} top_state_t;

	// command from the front end to the tree engine
	typedef struct packed {
		logic start;
		logic is_query;
		logic keep_acc;
	} eng_ctl_t;

	// engine status
	typedef struct packed {
		logic ready;
		logic done;
	} eng_sts_t;

endpackage

// ----- hdl/crat_ram.sv -----
module crat_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/crat_alu.sv -----
module crat_alu (
	input  crat_pkg::alu_op_t op,
	input  logic [63:0]       x,
	input  crat_pkg::node_t   y,
	output crat_pkg::node_t   z
);
	import crat_pkg::*;

	logic [VAL_W-1:0] sum_ad;
	logic [VAL_W-1:0] sum_mn;
	logic             x_less;

	// two wrapping adders and one signed compare, shared by all ALU operations
	assign sum_ad = y.ad + x;
	assign sum_mn = y.mn + x;
	assign x_less = $signed(x) < $signed(y.mn);

	always_comb begin
		z = y;
		unique case (op)
			ALU_BUMP: begin
				z.ad = sum_ad;
				z.mn = sum_mn;
			end
			ALU_MIN: begin
				z.mn = x_less ? x : y.mn;
			end
			ALU_ADDMN: begin
				z.mn = sum_mn;
			end
			default: begin
				z = y;
			end
		endcase
	end

endmodule

// ----- hdl/crat_engine.sv -----
module crat_engine #(
	parameter int unsigned LEAVES = crat_pkg::LEAVES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  crat_pkg::eng_ctl_t        ctl,
	input  logic [$clog2(LEAVES)-1:0] lo_leaf,
	input  logic [$clog2(LEAVES)-1:0] hi_leaf,
	input  logic [63:0]               amount,
	output crat_pkg::eng_sts_t        sts,
	output logic [63:0]               acc
);
	import crat_pkg::*;

	localparam int unsigned LOG   = $clog2(LEAVES);
	localparam int unsigned AW    = LOG + 1;
	localparam int unsigned DEPTH = 2 ** AW;
	localparam int unsigned LVW   = $clog2(LOG + 1);

	eng_state_t       state_q, state_d;
	logic [AW:0]      lo_q, lo_d, hi_q, hi_d;
	logic [AW-1:0]    lleaf_q, lleaf_d, rleaf_q, rleaf_d;
	logic [AW-1:0]    node_q, node_d;
	logic [AW-1:0]    clr_q, clr_d;
	logic [LVW-1:0]   lvl_q, lvl_d;
	logic             side_q, side_d;
	logic             ret_sh_q, ret_sh_d;
	logic             query_q, query_d;
	logic [VAL_W-1:0] acc_q, acc_d, pend_q, pend_d, tmp_q, tmp_d, amt_q, amt_d;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	node_t            wdata, rdata;
	alu_op_t          alu_op;
	logic [VAL_W-1:0] alu_x;
	node_t            alu_y, alu_z;
	logic [AW-1:0]    path, shifted, child0, child1;
	logic [AW:0]      hi_dec;

	crat_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	crat_alu u_alu (
		.op (alu_op),
		.x  (alu_x),
		.y  (alu_y),
		.z  (alu_z)
	);

	assign path    = side_q ? rleaf_q : lleaf_q;
	assign shifted = path >> lvl_q;
	assign child0  = {node_q[AW-2:0], 1'b0};
	assign child1  = {node_q[AW-2:0], 1'b1};
	assign hi_dec  = hi_q - (AW+1)'(1);

	// sequencer: clear, push pending adds, walk cover nodes, fix minima
	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		lleaf_d  = lleaf_q;
		rleaf_d  = rleaf_q;
		node_d   = node_q;
		clr_d    = clr_q;
		lvl_d    = lvl_q;
		side_d   = side_q;
		ret_sh_d = ret_sh_q;
		query_d  = query_q;
		acc_d    = acc_q;
		pend_d   = pend_q;
		tmp_d    = tmp_q;
		amt_d    = amt_q;
		we       = 1'b0;
		waddr    = node_q;
		wdata    = rdata;
		raddr    = node_q;
		alu_op   = ALU_BUMP;
		alu_x    = amt_q;
		alu_y    = rdata;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				clr_d = clr_q + AW'(1);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (ctl.start) begin
					lleaf_d = {1'b1, lo_leaf};
					rleaf_d = {1'b1, hi_leaf};
					lo_d    = {2'b01, lo_leaf};
					hi_d    = {2'b01, hi_leaf} + (AW+1)'(1);
					lvl_d   = LVW'(LOG);
					side_d  = 1'b0;
					query_d = ctl.is_query;
					amt_d   = amount;
					if (!ctl.keep_acc) begin
						acc_d = NEUTRAL_MIN;
					end
					state_d = ctl.is_query ? ST_PSEL : ST_CL;
				end
			end
			// push down along both boundary paths, top level first
			ST_PSEL: begin
				if (lvl_q == '0) begin
					state_d = ST_CL;
				end else begin
					node_d  = shifted;
					raddr   = shifted;
					state_d = ST_PCHK;
				end
			end
			ST_PCHK: begin
				if (rdata.ad == '0) begin
					state_d = ST_PNX;
				end else begin
					we       = 1'b1;
					waddr    = node_q;
					wdata.ad = '0;
					wdata.mn = rdata.mn;
					pend_d   = rdata.ad;
					raddr    = child0;
					state_d  = ST_PC0;
				end
			end
			ST_PC0: begin
				alu_x   = pend_q;
				we      = 1'b1;
				waddr   = child0;
				wdata   = alu_z;
				raddr   = child1;
				state_d = ST_PC1;
			end
			ST_PC1: begin
				alu_x   = pend_q;
				we      = 1'b1;
				waddr   = child1;
				wdata   = alu_z;
				state_d = ST_PNX;
			end
			ST_PNX: begin
				if (!side_q) begin
					side_d = 1'b1;
				end else begin
					side_d = 1'b0;
					lvl_d  = lvl_q - LVW'(1);
				end
				state_d = ST_PSEL;
			end
			// bottom-up walk over the nodes that cover the range
			ST_CL: begin
				if (lo_q >= hi_q) begin
					node_d  = lleaf_q >> 1;
					side_d  = 1'b0;
					state_d = query_q ? ST_DONE : ST_RC0;
				end else if (lo_q[0]) begin
					node_d   = lo_q[AW-1:0];
					raddr    = lo_q[AW-1:0];
					lo_d     = lo_q + (AW+1)'(1);
					ret_sh_d = 1'b0;
					state_d  = ST_VIS;
				end else begin
					state_d = ST_CR;
				end
			end
			ST_CR: begin
				if (hi_q[0]) begin
					node_d   = hi_dec[AW-1:0];
					raddr    = hi_dec[AW-1:0];
					hi_d     = hi_dec;
					ret_sh_d = 1'b1;
					state_d  = ST_VIS;
				end else begin
					state_d = ST_SH;
				end
			end
			ST_SH: begin
				lo_d    = lo_q >> 1;
				hi_d    = hi_q >> 1;
				state_d = ST_CL;
			end
			ST_VIS: begin
				if (query_q) begin
					alu_op = ALU_MIN;
					alu_x  = acc_q;
					acc_d  = alu_z.mn;
				end else begin
					we    = 1'b1;
					waddr = node_q;
					wdata = alu_z;
				end
				state_d = ret_sh_q ? ST_SH : ST_CR;
			end
			// rebuild minima above both boundary leaves
			ST_RC0: begin
				if (node_q == '0) begin
					if (!side_q) begin
						side_d = 1'b1;
						node_d = rleaf_q >> 1;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					raddr   = node_q;
					state_d = ST_RC1;
				end
			end
			ST_RC1: begin
				pend_d  = rdata.ad;
				raddr   = child0;
				state_d = ST_RC2;
			end
			ST_RC2: begin
				tmp_d   = rdata.mn;
				raddr   = child1;
				state_d = ST_RC3;
			end
			ST_RC3: begin
				alu_op  = ALU_MIN;
				alu_x   = tmp_q;
				tmp_d   = alu_z.mn;
				state_d = ST_RC4;
			end
			ST_RC4: begin
				alu_op   = ALU_ADDMN;
				alu_x    = pend_q;
				alu_y.ad = pend_q;
				alu_y.mn = tmp_q;
				we       = 1'b1;
				waddr    = node_q;
				wdata    = alu_z;
				node_d   = node_q >> 1;
				state_d  = ST_RC0;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		lleaf_q  <= lleaf_d;
		rleaf_q  <= rleaf_d;
		node_q   <= node_d;
		lvl_q    <= lvl_d;
		side_q   <= side_d;
		ret_sh_q <= ret_sh_d;
		query_q  <= query_d;
		acc_q    <= acc_d;
		pend_q   <= pend_d;
		tmp_q    <= tmp_d;
		amt_q    <= amt_d;
	end

	assign sts.ready = (state_q == ST_IDLE);
	assign sts.done  = (state_q == ST_DONE);
	assign acc       = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE)
		else $error("engine started while busy");

	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CL |-> lo_q <= hi_q)
		else $error("cover walk bounds crossed");

	a_rebuild_inner: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RC1 |-> !node_q[AW-1])
		else $error("rebuild reached a leaf");

endmodule

// ----- hdl/circular_range_add_min_tree.sv -----
// Range add / range minimum over a circular array of signed 64-bit cells,
// kept in a lazy segment tree of 2*2^ceil(log2(LEAVES)) nodes in one RAM.
// Each word is worked on alone by one shared add/compare unit stepping
// through the tree. A range add walks the cover nodes and then rebuilds
// minima above both boundary leaves; a query first pushes pending adds
// down both boundary paths and then does the same cover walk. A wrapping
// range runs both halves in turn. Out of range words are answered without
// running the tree. After reset a clearing pass writes every node, during
// which no word is taken; register writes are taken at any time.
module circular_range_add_min_tree #(
	parameter int unsigned LEAVES = crat_pkg::LEAVES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_ready,
	input  crat_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output crat_pkg::rsp_word_t rsp
);
	import crat_pkg::*;

	localparam int unsigned LOG          = $clog2(LEAVES);
	localparam logic [2:0]  REG_SIZE_ADR = 3'd0;

	logic [POS_W-1:0] size_q;
	top_state_t       tstate_q, tstate_d;
	eng_ctl_t         ctl_q, ctl_d;
	eng_sts_t         sts;
	logic [VAL_W-1:0] acc;
	logic [LOG-1:0]   eng_lo_q, eng_hi_q, lo2_q, hi2_q;
	logic             wrap_q, query_q;
	logic [VAL_W-1:0] amt_q;
	rsp_word_t        res_q, res_d, rsp_q;
	logic             rsp_valid_q;

	logic [POS_W-1:0] eff;
	logic             bad, wrap, take, load_out;
	logic [LOG-1:0]   first_leaf, last_leaf, eff_leaf;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_SIZE_ADR) ? {{(32-POS_W){1'b0}}, size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && paddr == REG_SIZE_ADR) begin
			size_q <= pwdata[POS_W-1:0];
		end
	end

	// check and split the incoming word
	assign eff = (32'(size_q) > LEAVES) ? POS_W'(LEAVES) : size_q;
	assign bad = (req.first_position == '0) || (req.last_position == '0) ||
		(req.first_position > eff) || (req.last_position > eff);
	assign wrap       = req.first_position > req.last_position;
	assign first_leaf = LOG'(req.first_position - POS_W'(1));
	assign last_leaf  = LOG'(req.last_position - POS_W'(1));
	assign eff_leaf   = LOG'(eff - POS_W'(1));

	assign req_ready = (tstate_q == T_IDLE) && sts.ready;
	assign take      = req_valid && req_ready;
	assign load_out  = (tstate_q == T_WAIT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		tstate_d = tstate_q;
		ctl_d    = '0;
		res_d    = res_q;
		unique case (tstate_q)
			T_IDLE: begin
				if (take) begin
					if (bad) begin
						res_d.min_value = '0;
						res_d.was_query = req.func;
						res_d.bad_range = 1'b1;
						tstate_d        = T_WAIT;
					end else begin
						ctl_d.start    = 1'b1;
						ctl_d.is_query = req.func;
						tstate_d       = T_RUN1;
					end
				end
			end
			T_RUN1: begin
				if (sts.done) begin
					if (wrap_q) begin
						ctl_d.start    = 1'b1;
						ctl_d.is_query = query_q;
						ctl_d.keep_acc = 1'b1;
						tstate_d       = T_RUN2;
					end else begin
						res_d.min_value = query_q ? acc : '0;
						res_d.was_query = query_q;
						res_d.bad_range = 1'b0;
						tstate_d        = T_WAIT;
					end
				end
			end
			T_RUN2: begin
				if (sts.done) begin
					res_d.min_value = query_q ? acc : '0;
					res_d.was_query = query_q;
					res_d.bad_range = 1'b0;
					tstate_d        = T_WAIT;
				end
			end
			T_WAIT: begin
				if (load_out) begin
					tstate_d = T_IDLE;
				end
			end
			default: begin
				tstate_d = T_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q    <= T_IDLE;
			ctl_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			tstate_q <= tstate_d;
			ctl_q    <= ctl_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold ranges, amount and result words
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (take) begin
			eng_lo_q <= wrap ? '0 : first_leaf;
			eng_hi_q <= last_leaf;
			lo2_q    <= first_leaf;
			hi2_q    <= eff_leaf;
			wrap_q   <= wrap;
			query_q  <= req.func;
			amt_q    <= {{(VAL_W-32){req.amount[31]}}, req.amount};
		end else if (tstate_q == T_RUN1 && sts.done && wrap_q) begin
			eng_lo_q <= lo2_q;
			eng_hi_q <= hi2_q;
		end
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	crat_engine #(
		.LEAVES (LEAVES)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_q),
		.lo_leaf (eng_lo_q),
		.hi_leaf (eng_hi_q),
		.amount  (amt_q),
		.sts     (sts),
		.acc     (acc)
	);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> tstate_q != T_IDLE)
		else $error("word taken but front end stayed idle");

	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> tstate_q == T_RUN1 || tstate_q == T_RUN2)
		else $error("engine finished with no range in flight");

	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tstate_q == T_WAIT && rsp_valid && !rsp_ready |=> tstate_q == T_WAIT)
		else $error("result left while output stalled");

endmodule
